FILE: sv/dca_pkg.sv
// ----------------------------------------------------------------------------
// Divisor count package
// Widths, sizes and the sequencer state type shared by the divisor count block
// and its channel interfaces.
// ----------------------------------------------------------------------------
package dca_pkg;

  // Width of the incoming integer.
  localparam int VALUE_WIDTH = 31;

  // Width of the reported divisor count. The count saturates at its maximum.
  localparam int COUNT_WIDTH = 11;

  // Width of the wrapping running total.
  localparam int TOTAL_WIDTH = 32;

  // Trial divisors never pass the square root by more than one, so half the
  // value width plus some margin is enough.
  localparam int DIV_WIDTH = (VALUE_WIDTH + 1) / 2 + 1;

  // Counter over the bit steps of one division.
  localparam int STEP_WIDTH = $clog2(VALUE_WIDTH);

  // Count value used when the true count does not fit.
  localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;

  // Sequencer states.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_CHECK,
    ST_FINISH
  } dca_state_t;

endpackage : dca_pkg

FILE: sv/dca_channels.sv
// ----------------------------------------------------------------------------
// Divisor count channels
// Valid/ready interfaces for the request channel and the result channel.
// ----------------------------------------------------------------------------

// Request channel: one integer per request.
interface dca_in_if import dca_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic [VALUE_WIDTH-1:0] value;

  modport source (output valid, output value, input ready);
  modport sink   (input valid, input value, output ready);
endinterface : dca_in_if

// Result channel: divisor count and running total.
interface dca_out_if import dca_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic [COUNT_WIDTH-1:0] divisor_count;
  logic [TOTAL_WIDTH-1:0] running_total;

  modport source (output valid, output divisor_count, output running_total, input ready);
  modport sink   (input valid, input divisor_count, input running_total, output ready);
endinterface : dca_out_if

FILE: sv/divisor_count_accumulate.sv
// ----------------------------------------------------------------------------
// Divisor count with running total
// Counts the exact divisors of each request value by trial division and
// reports the count together with a wrapping sum of all counts.
// ----------------------------------------------------------------------------
// Usage:
//   The request channel in_ch carries one unsigned integer per request; the
//   result channel out_ch returns one result for each request, in order, with
//   the divisor count and the running total after that count was added.
//   Both channels transfer at a rising edge where valid and ready are high.
//   Trial divisors d = 1, 2, ... are tried while d <= value / d. Each trial
//   runs one shared restoring divider, one quotient bit per cycle, over all
//   VALUE_WIDTH dividend bits, then a check state tests and counts. A zero
//   value skips the division and goes straight to the finish state.
//   in_ch.ready is high only while the sequencer is idle.
//   The result sits in an output register, so a new request is accepted while
//   the previous result still waits; a stalled receiver holds the next result
//   in the sequencer until the output register frees up.
//   Reset (rst_n low, synchronous) clears the running total, drops any result
//   in flight and returns the sequencer to idle.
// ----------------------------------------------------------------------------
module divisor_count_accumulate import dca_pkg::*; (
  input  logic            clk,
  input  logic            rst_n,
  dca_in_if.sink          in_ch,
  dca_out_if.source       out_ch
);

  localparam int PAD_WIDTH = VALUE_WIDTH - DIV_WIDTH;

  dca_state_t state_r, state_nxt;

  logic [VALUE_WIDTH-1:0] val_r, val_nxt;
  logic [VALUE_WIDTH-1:0] quo_r, quo_nxt;
  logic [DIV_WIDTH-1:0]   rem_r, rem_nxt;
  logic [DIV_WIDTH-1:0]   dsr_r, dsr_nxt;
  logic [STEP_WIDTH-1:0]  step_r, step_nxt;
  logic [COUNT_WIDTH-1:0] cnt_r, cnt_nxt;
  logic [TOTAL_WIDTH-1:0] total_r, total_nxt;
  logic [COUNT_WIDTH-1:0] out_count_r, out_count_nxt;
  logic [TOTAL_WIDTH-1:0] out_total_r, out_total_nxt;
  logic                   out_valid_r, out_valid_nxt;

  // Sequencer controls.
  logic accept;
  logic out_free;
  logic out_load;
  logic value_zero;
  logic trial_more;

  // Divider step and trial test signals.
  logic [DIV_WIDTH:0]     trial;
  logic                   trial_ge;
  logic [VALUE_WIDTH-1:0] dsr_ext;
  logic [1:0]             inc;
  logic [COUNT_WIDTH:0]   cnt_sum;

  assign value_zero = (in_ch.value == '0);
  assign out_free   = !out_valid_r || out_ch.ready;
  assign dsr_ext    = {{PAD_WIDTH{1'b0}}, dsr_r};
  assign trial_more = (dsr_ext <= quo_r);

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_ch.valid) begin
          state_nxt = value_zero ? ST_FINISH : ST_DIV;
        end
      end
      ST_DIV: begin
        if (step_r == '0) begin
          state_nxt = ST_CHECK;
        end
      end
      ST_CHECK: begin
        state_nxt = trial_more ? ST_DIV : ST_FINISH;
      end
      ST_FINISH: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Sequencer outputs.
  always_comb begin
    in_ch.ready = 1'b0;
    out_load    = 1'b0;
    unique case (state_r)
      ST_IDLE:   in_ch.ready = 1'b1;
      ST_FINISH: out_load    = out_free;
      default: begin
        in_ch.ready = 1'b0;
        out_load    = 1'b0;
      end
    endcase
  end

  assign accept = in_ch.valid && in_ch.ready;

  // One restoring division step: shift in the next dividend bit and subtract.
  assign trial    = {rem_r, quo_r[VALUE_WIDTH-1]};
  assign trial_ge = (trial >= {1'b0, dsr_r});

  // Divisor pairs count twice, a square root once; the count saturates.
  assign inc     = (dsr_ext == quo_r) ? 2'd1 : 2'd2;
  assign cnt_sum = {1'b0, cnt_r} + {{(COUNT_WIDTH-1){1'b0}}, inc};

  // Datapath next values.
  always_comb begin
    val_nxt       = val_r;
    quo_nxt       = quo_r;
    rem_nxt       = rem_r;
    dsr_nxt       = dsr_r;
    step_nxt      = step_r;
    cnt_nxt       = cnt_r;
    total_nxt     = total_r;
    out_count_nxt = out_count_r;
    out_total_nxt = out_total_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;

    if (accept) begin
      val_nxt  = in_ch.value;
      quo_nxt  = in_ch.value;
      rem_nxt  = '0;
      dsr_nxt  = {{(DIV_WIDTH-1){1'b0}}, 1'b1};
      step_nxt = STEP_WIDTH'(VALUE_WIDTH - 1);
      cnt_nxt  = '0;
    end

    if (state_r == ST_DIV) begin
      rem_nxt = trial_ge ? trial[DIV_WIDTH-1:0] - dsr_r : trial[DIV_WIDTH-1:0];
      quo_nxt = {quo_r[VALUE_WIDTH-2:0], trial_ge};
      if (step_r != '0) begin
        step_nxt = step_r - STEP_WIDTH'(1);
      end
    end

    // Test the finished trial and start the next one.
    if (state_r == ST_CHECK && trial_more) begin
      if (rem_r == '0) begin
        cnt_nxt = cnt_sum[COUNT_WIDTH] ? COUNT_MAX : cnt_sum[COUNT_WIDTH-1:0];
      end
      dsr_nxt  = dsr_r + DIV_WIDTH'(1);
      quo_nxt  = val_r;
      rem_nxt  = '0;
      step_nxt = STEP_WIDTH'(VALUE_WIDTH - 1);
    end

    // Hand the result to the output register.
    if (out_load) begin
      total_nxt     = total_r + {{(TOTAL_WIDTH-COUNT_WIDTH){1'b0}}, cnt_r};
      out_count_nxt = cnt_r;
      out_total_nxt = total_nxt;
      out_valid_nxt = 1'b1;
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      total_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      total_r     <= total_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    val_r       <= val_nxt;
    quo_r       <= quo_nxt;
    rem_r       <= rem_nxt;
    dsr_r       <= dsr_nxt;
    step_r      <= step_nxt;
    cnt_r       <= cnt_nxt;
    out_count_r <= out_count_nxt;
    out_total_r <= out_total_nxt;
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.divisor_count = out_count_r;
  assign out_ch.running_total = out_total_r;

`ifndef SYNTH
  // The trial divisor is never zero while dividing.
  a_dsr_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_DIV |-> dsr_r != '0)
    else $error("trial divisor is zero during division");

  // A finished division leaves a remainder below the divisor.
  a_rem_below: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_CHECK |-> rem_r < dsr_r)
    else $error("remainder not below divisor");

  // A zero value goes straight to the result with a count of zero.
  a_zero_value: assert property (@(posedge clk) disable iff (!rst_n)
    accept && value_zero |=> state_r == ST_FINISH && cnt_r == '0)
    else $error("zero value did not give an empty count");

  // A loaded result carries the total advanced by its own count.
  a_total_update: assert property (@(posedge clk) disable iff (!rst_n)
    out_load |=> out_valid_r && out_total_r == total_r
      && out_total_r == $past(total_r) + {{(TOTAL_WIDTH-COUNT_WIDTH){1'b0}}, $past(cnt_r)})
    else $error("running total not advanced by the count");
`endif

endmodule : divisor_count_accumulate

FILE: tb/sv/dca_result_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Divisor count result checker
// Watches both channels of the divisor count block. Each accepted request is
// run through a local trial-division predictor. The predicted count and
// running total are queued, and every accepted result is compared field by
// field with the oldest queued prediction.
// ----------------------------------------------------------------------------
module dca_result_checker import dca_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  dca_in_if    in_ch,
  dca_out_if   out_ch,
  output int   mismatch_count,
  output int   outstanding
);

  typedef struct packed {
    logic [COUNT_WIDTH-1:0] divisor_count;
    logic [TOTAL_WIDTH-1:0] running_total;
  } tally_t;

  tally_t                 expected_tallies[$];
  logic [TOTAL_WIDTH-1:0] total_sum;

  // Count the exact divisors of v by testing candidates up to the square root.
  // Each divisor below the root pairs with one above it. A root counts once.
  function automatic logic [COUNT_WIDTH-1:0] divisors_of(logic [VALUE_WIDTH-1:0] v);
    longint unsigned num;
    longint unsigned cand;
    longint unsigned found;
    num   = 64'(v);
    found = 0;
    if (num == 0) begin
      return '0;
    end
    for (cand = 1; cand <= num / cand; cand++) begin
      if (num % cand == 0) begin
        found += (cand == num / cand) ? 64'd1 : 64'd2;
      end
    end
    if (found > 64'(COUNT_MAX)) begin
      found = 64'(COUNT_MAX);
    end
    return found[COUNT_WIDTH-1:0];
  endfunction

  // Results are checked before new requests are queued, so a result can never
  // be matched against a request accepted at the same edge.
  always @(posedge clk) begin
    tally_t                 head;
    logic [COUNT_WIDTH-1:0] cnt;
    if (!rst_n) begin
      expected_tallies.delete();
      total_sum = '0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (expected_tallies.size() == 0) begin
          mismatch_count++;
          $display("%0t: unexpected result count=%0d total=%0d", $time,
                   out_ch.divisor_count, out_ch.running_total);
        end else begin
          head = expected_tallies.pop_front();
          if (out_ch.divisor_count !== head.divisor_count) begin
            mismatch_count++;
            $display("%0t: divisor_count expected %0d, got %0d", $time,
                     head.divisor_count, out_ch.divisor_count);
          end
          if (out_ch.running_total !== head.running_total) begin
            mismatch_count++;
            $display("%0t: running_total expected %0d, got %0d", $time,
                     head.running_total, out_ch.running_total);
          end
        end
      end
      if (in_ch.valid && in_ch.ready) begin
        cnt       = divisors_of(in_ch.value);
        total_sum = total_sum + TOTAL_WIDTH'(cnt);
        expected_tallies.push_back('{divisor_count: cnt, running_total: total_sum});
      end
    end
    outstanding = expected_tallies.size();
  end

endmodule : dca_result_checker

FILE: tb/sv/tb_divisor_count_accumulate.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Divisor count testbench
// Sends corner values and then random values of mostly modest size to the
// divisor count block, with bursty requests and a receiver that stalls on a
// pattern of its own. Checking is done by the result checker beside the block.
// ----------------------------------------------------------------------------
module tb_divisor_count_accumulate;
  import dca_pkg::*;

  localparam int RANDOM_REQUESTS = 100;
  localparam int LONG_HOLD       = 2000;
  localparam int DRAIN_CYCLES    = 4 * (VALUE_WIDTH + 1);
  // The limit leaves room for the largest corner value and for the random
  // requests, which all stay below 2^20.
  localparam longint CYCLE_LIMIT = 20_000_000;

  localparam int unsigned CORNER_VALUES [15] = '{
    0, 1, 2, 3, 4, 12, 36, 49, 97, 961, 65536, 720720, 2147483647, 0, 1
  };

  logic   clk = 1'b0;
  logic   rst_n;
  int     mismatch_count;
  int     outstanding;
  int     burst_left;
  int     hold_orders;
  int     holds_done;
  longint cycle_count;

  dca_in_if  in_ch ();
  dca_out_if out_ch ();

  divisor_count_accumulate u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  dca_result_checker u_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_ch          (in_ch),
    .out_ch         (out_ch),
    .mismatch_count (mismatch_count),
    .outstanding    (outstanding)
  );

  // Clock with a 12 ns period.
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Watchdog on the total run length.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // Present one request at the current falling edge and hold it until taken.
  // Returns at the falling edge after the request was accepted.
  task automatic offer(input logic [VALUE_WIDTH-1:0] v);
    in_ch.valid <= 1'b1;
    in_ch.value <= v;
    do @(posedge clk); while (!in_ch.ready);
    @(negedge clk);
  endtask

  // Bursts of random length, separated by random gaps with valid low.
  task automatic pace();
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 10);
      gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 15);
      if (gap > 0) begin
        in_ch.valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    burst_left--;
  endtask

  // Stop sending until every queued prediction has been matched.
  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    do @(negedge clk); while (outstanding != 0);
  endtask

  // Mostly small values keep the trial division short; one in ten reaches
  // up to 20 bits, and a few are zero.
  function automatic logic [VALUE_WIDTH-1:0] random_value();
    int unsigned bits;
    bits = ($urandom_range(0, 9) == 0) ? $urandom_range(17, 20) : $urandom_range(1, 16);
    if ($urandom_range(0, 19) == 0) begin
      return '0;
    end
    return VALUE_WIDTH'($urandom_range(0, (32'd1 << bits) - 1));
  endfunction

  // Receiver: a stall pattern picked at random from four modes on a phase counter,
  // plus long hold-offs on request from the stimulus.
  initial begin
    int mode;
    int phase;
    out_ch.ready = 1'b0;
    holds_done   = 0;
    mode         = 0;
    phase        = 0;
    wait (rst_n === 1'b1);
    forever begin
      @(negedge clk);
      if (holds_done < hold_orders) begin
        out_ch.ready <= 1'b0;
        repeat (LONG_HOLD - 1) @(negedge clk);
        holds_done++;
      end else begin
        if (phase % 50 == 0) begin
          mode = $urandom_range(0, 3);
        end
        phase++;
        case (mode)
          0: begin
            out_ch.ready <= 1'b1;
          end
          1: begin
            out_ch.ready <= ($urandom_range(0, 1) == 1);
          end
          2: begin
            out_ch.ready <= ($urandom_range(0, 3) == 0);
          end
          default: begin
            out_ch.ready <= (phase % 3 == 0);
          end
        endcase
      end
    end
  end

  // Stimulus and verdict.
  initial begin
    in_ch.valid = 1'b0;
    in_ch.value = '0;
    rst_n       = 1'b0;
    burst_left  = 0;
    hold_orders = 0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Corner values: zero before and after nonzero totals, one, primes,
    // perfect squares, a highly composite value and the largest value.
    foreach (CORNER_VALUES[i]) begin
      pace();
      offer(VALUE_WIDTH'(CORNER_VALUES[i]));
    end
    wait_drained();

    for (int i = 0; i < RANDOM_REQUESTS; i++) begin
      if (i == 30) begin
        // Hold the receiver off while small requests keep coming, so the
        // output register and the sequencer both fill and the input stalls.
        hold_orders++;
        for (int k = 0; k < 6; k++) begin
          offer(VALUE_WIDTH'($urandom_range(0, 63)));
        end
      end
      if (i == 70) begin
        wait_drained();
      end
      pace();
      offer(random_value());
    end

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && outstanding == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule : tb_divisor_count_accumulate

FILE: files.f
sv/dca_pkg.sv
sv/dca_channels.sv
sv/divisor_count_accumulate.sv
tb/sv/dca_result_checker.sv
tb/sv/tb_divisor_count_accumulate.sv
